### hw/rtl/lted_pkg.sv
// ----------------------------------------------------------------------------
// lted_pkg
// Shared constants, types and register map for the luma threshold
// error diffusion core.
// ----------------------------------------------------------------------------
`default_nettype none

package lted_pkg;

  // Line store depth and derived index widths
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WCNT_W    = COL_W + 1;

  // Register field widths
  localparam int IMG_W_W = 13;
  localparam int COEF_W  = 16;
  localparam int PIX_W   = 8;
  localparam int LUMA_W  = 26;

  // Half of full-scale luma: 255 * 65536 / 2
  localparam logic [LUMA_W-1:0] LUMA_HALF = LUMA_W'(8355840);

  // Register reset values
  localparam logic [IMG_W_W-1:0] IMG_W_RST  = IMG_W_W'(640);
  localparam logic [COEF_W-1:0]  COEF_R_RST = COEF_W'(19595);
  localparam logic [COEF_W-1:0]  COEF_G_RST = COEF_W'(38470);
  localparam logic [COEF_W-1:0]  COEF_B_RST = COEF_W'(7471);

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_COEF_RED    = 2'd1,
    REG_COEF_GREEN  = 2'd2,
    REG_COEF_BLUE   = 2'd3
  } reg_idx_t;

  // Three 8-bit lanes: 0 red, 1 green, 2 blue
  typedef logic [2:0][PIX_W-1:0] rgb_t;

endpackage

`default_nettype wire

### hw/rtl/luma_threshold_error_diffusion_core.sv
// ----------------------------------------------------------------------------
// luma_threshold_error_diffusion_core
// One-bit error-diffusion dither of a raster RGB stream with a luma threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_ channel (valid/ready) in raster order; a word with
//   in_frame_start set restarts row and column. Each pixel yields exactly one
//   word on the out_ channel: out_is_white.
//   Width and luma weights are set through the APB port (psel/penable/...),
//   registers at 0x0 width, 0x4 red, 0x8 green, 0xC blue; write only while
//   the stream is idle.
//   An accepted pixel passes the input register, then the result register,
//   before out_valid. Throughput is one pixel per clock while out_ready is
//   high: the input register and line store read port are registered, and
//   the right-carry feedback (three 8x16 multiplies, add, compare, share
//   adds) is combinational. A row-end pixel writes its below-left share at
//   once, its below share in the next cycle from a one-entry write buffer;
//   reads are bypassed. When out_ready is low the result word holds, one
//   more pixel is held in the input register, then in_ready drops.
//   Reset (rst_n low, synchronous) restores the register defaults, empties
//   both stages and starts at the first row, column 0. The line store is not
//   cleared: the first row never reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_threshold_error_diffusion_core import lted_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input pixel channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_frame_start,
  input  wire logic [PIX_W-1:0]  in_red_in,
  input  wire logic [PIX_W-1:0]  in_green_in,
  input  wire logic [PIX_W-1:0]  in_blue_in,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_is_white,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers
  logic [IMG_W_W-1:0] img_width_r;
  logic [COEF_W-1:0]  coef_red_r;
  logic [COEF_W-1:0]  coef_green_r;
  logic [COEF_W-1:0]  coef_blue_r;
  reg_idx_t           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= IMG_W_RST;
      coef_red_r   <= COEF_R_RST;
      coef_green_r <= COEF_G_RST;
      coef_blue_r  <= COEF_B_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_IMAGE_WIDTH: img_width_r  <= pwdata[IMG_W_W-1:0];
        REG_COEF_RED:    coef_red_r   <= pwdata[COEF_W-1:0];
        REG_COEF_GREEN:  coef_green_r <= pwdata[COEF_W-1:0];
        REG_COEF_BLUE:   coef_blue_r  <= pwdata[COEF_W-1:0];
        default:         img_width_r  <= img_width_r;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH: prdata = {{(32-IMG_W_W){1'b0}}, img_width_r};
      REG_COEF_RED:    prdata = {{(32-COEF_W){1'b0}}, coef_red_r};
      REG_COEF_GREEN:  prdata = {{(32-COEF_W){1'b0}}, coef_green_r};
      REG_COEF_BLUE:   prdata = {{(32-COEF_W){1'b0}}, coef_blue_r};
      default:         prdata = '0;
    endcase
  end

  // Effective width: 0 acts as 1, clamp to the line store depth
  logic [WCNT_W-1:0] w_eff;

  always_comb begin
    if (img_width_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(img_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(img_width_r);
    end
  end

  // Pipeline handshake
  logic s0_valid_r;
  logic s0_fire;
  logic in_fire;
  logic out_valid_r;
  logic out_is_white_r;

  assign s0_fire   = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s0_valid_r || s0_fire;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_is_white = out_is_white_r;

  // Front position tracking, resolved at accept time
  logic [COL_W-1:0] col_f_r;
  logic             first_f_r;
  logic [COL_W-1:0] acc_col;
  logic             acc_first;
  logic             acc_row_end;
  logic [COL_W-1:0] col_f_nxt;
  logic             first_f_nxt;

  always_comb begin
    if (in_frame_start) begin
      acc_col   = '0;
      acc_first = 1'b1;
    end else if ({1'b0, col_f_r} >= w_eff) begin
      acc_col   = '0;
      acc_first = 1'b0;
    end else begin
      acc_col   = col_f_r;
      acc_first = first_f_r;
    end
    acc_row_end = ({1'b0, acc_col} + WCNT_W'(1)) >= w_eff;
    if (acc_row_end) begin
      col_f_nxt   = '0;
      first_f_nxt = 1'b0;
    end else begin
      col_f_nxt   = COL_W'(acc_col + 1'b1);
      first_f_nxt = acc_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_f_r   <= '0;
      first_f_r <= 1'b1;
    end else if (in_fire) begin
      col_f_r   <= col_f_nxt;
      first_f_r <= first_f_nxt;
    end
  end

  // Line store write port (one write per cycle)
  logic             we;
  logic [COL_W-1:0] waddr;
  rgb_t             wdata;
  logic             pend_valid_r;
  logic [COL_W-1:0] pend_addr_r;
  rgb_t             pend_data_r;

  // Stage 0: input register
  rgb_t             s0_pix_r;
  logic [COL_W-1:0] s0_col_r;
  logic             s0_first_r;
  logic             s0_row_end_r;
  logic             s0_byp_r;
  rgb_t             s0_byp_data_r;
  rgb_t             mem_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_fire) begin
      s0_valid_r <= 1'b1;
    end else if (s0_fire) begin
      s0_valid_r <= 1'b0;
    end
  end

  // Stage 0 payload and read bypass for a write landing on the same entry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_pix_r      <= {in_blue_in, in_green_in, in_red_in};
      s0_col_r      <= acc_col;
      s0_first_r    <= acc_first;
      s0_row_end_r  <= acc_row_end;
      s0_byp_r      <= we && (waddr == acc_col);
      s0_byp_data_r <= wdata;
    end else if (s0_valid_r && !s0_fire && we && (waddr == s0_col_r)) begin
      s0_byp_r      <= 1'b1;
      s0_byp_data_r <= wdata;
    end
  end

  // Line store
  rgb_t line_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= line_mem[acc_col];
    end
  end

  // Carries from the previous pixel of the row
  rgb_t rc_r;
  rgb_t np0_r;
  rgb_t np1_r;

  // Stage 1: raise, luma threshold, error shares
  rgb_t              rc_eff;
  rgb_t              np0_eff;
  rgb_t              np1_eff;
  rgb_t              below;
  rgb_t              raised;
  rgb_t              err;
  rgb_t              rc_new;
  rgb_t              done_new;
  rgb_t              np0_new;
  rgb_t              np1_new;
  logic [PIX_W+1:0]  sum [3];
  logic [10:0]       e7 [3];
  logic [10:0]       e5 [3];
  logic [10:0]       e3 [3];
  logic [23:0]       prod_r;
  logic [23:0]       prod_g;
  logic [23:0]       prod_b;
  logic [LUMA_W-1:0] luma;
  logic              white;

  always_comb begin
    // carries are always clear at the start of a row
    rc_eff  = (s0_col_r == '0) ? '0 : rc_r;
    np0_eff = (s0_col_r == '0) ? '0 : np0_r;
    np1_eff = (s0_col_r == '0) ? '0 : np1_r;
    if (s0_first_r) begin
      below = '0;
    end else if (s0_byp_r) begin
      below = s0_byp_data_r;
    end else begin
      below = mem_rd_r;
    end

    // saturating add of pending errors
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = {2'b00, s0_pix_r[ch]} + {2'b00, rc_eff[ch]} + {2'b00, below[ch]};
      raised[ch] = (sum[ch] > (PIX_W+2)'(255)) ? 8'hFF : sum[ch][PIX_W-1:0];
    end

    // luma product and threshold
    prod_r = 24'(raised[0]) * 24'(coef_red_r);
    prod_g = 24'(raised[1]) * 24'(coef_green_r);
    prod_b = 24'(raised[2]) * 24'(coef_blue_r);
    luma   = LUMA_W'(prod_r) + LUMA_W'(prod_g) + LUMA_W'(prod_b);
    white  = luma >= LUMA_HALF;

    // floored shares: 7/16 right, 3/16, 5/16, 1/16 next row
    for (int ch = 0; ch < 3; ch++) begin
      err[ch]      = white ? '0 : raised[ch];
      e7[ch]       = 11'(err[ch]) * 11'd7;
      e5[ch]       = 11'(err[ch]) * 11'd5;
      e3[ch]       = 11'(err[ch]) * 11'd3;
      rc_new[ch]   = PIX_W'(e7[ch] >> 4);
      done_new[ch] = np0_eff[ch] + PIX_W'(e3[ch] >> 4);
      np0_new[ch]  = np1_eff[ch] + PIX_W'(e5[ch] >> 4);
      np1_new[ch]  = {4'd0, err[ch][7:4]};
    end
  end

  // Write select: the deferred row-end write wins; it never meets another
  always_comb begin
    we    = 1'b0;
    waddr = s0_col_r;
    wdata = np0_new;
    if (pend_valid_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = pend_data_r;
    end else if (s0_fire && (s0_col_r != '0)) begin
      we    = 1'b1;
      waddr = COL_W'(s0_col_r - 1'b1);
      wdata = done_new;
    end else if (s0_fire && s0_row_end_r) begin
      // single-pixel rows: below share goes to column 0 directly
      we    = 1'b1;
      waddr = s0_col_r;
      wdata = np0_new;
    end
  end

  // Deferred below write at row end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= s0_fire && s0_row_end_r && (s0_col_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      pend_addr_r <= s0_col_r;
      pend_data_r <= np0_new;
    end
  end

  // Row carries
  always_ff @(posedge clk) begin
    if (s0_fire && !s0_row_end_r) begin
      rc_r  <= rc_new;
      np0_r <= np0_new;
      np1_r <= np1_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      out_is_white_r <= white;
    end
  end

endmodule

`default_nettype wire

### dv/lted_dither_checker.sv
// ----------------------------------------------------------------------------
// lted_dither_checker
// Watches the pixel, result and register ports of the luma threshold error
// diffusion core. It keeps its own copy of the width and luma weights, runs
// a bit-exact dither predictor on every accepted pixel word, and compares
// each accepted result word in order. Register reads are checked against
// the shadow copy.
// ----------------------------------------------------------------------------
`default_nettype none

module lted_dither_checker import lted_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              in_frame_start,
  input  wire logic [PIX_W-1:0]  in_red_in,
  input  wire logic [PIX_W-1:0]  in_green_in,
  input  wire logic [PIX_W-1:0]  in_blue_in,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_is_white,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic [31:0]       prdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     words_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers
  logic [IMG_W_W-1:0] width_q;
  logic [COEF_W-1:0]  coef_red_q;
  logic [COEF_W-1:0]  coef_green_q;
  logic [COEF_W-1:0]  coef_blue_q;

  // Dither state: position, carries and the completed next-row errors
  int   col_pos;
  logic top_row;
  rgb_t carry_right;
  rgb_t row_open [2];
  rgb_t line_below [MAX_WIDTH];

  logic white_expected_q [$];
  int   mismatches = 0;
  int   outstanding = 0;

  assign fail_count    = mismatches;
  assign words_pending = outstanding;

  // Threshold one pixel and diffuse its error; returns the expected color bit
  function automatic logic dither_pixel(input logic fs, input logic [PIX_W-1:0] r, g, b);
    int          w;
    int          c;
    int          s;
    int          e;
    rgb_t        src;
    rgb_t        below;
    rgb_t        raised;
    rgb_t        share_right;
    rgb_t        share_done;
    rgb_t        share_np0;
    rgb_t        share_np1;
    logic [63:0] luma;
    logic        white;

    w = int'(width_q);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;

    if (fs) begin
      col_pos     = 0;
      top_row     = 1'b1;
      carry_right = '0;
      row_open[0] = '0;
      row_open[1] = '0;
    end
    // width lowered under the current column: start a new row first
    if (col_pos >= w) begin
      col_pos     = 0;
      top_row     = 1'b0;
      carry_right = '0;
      row_open[0] = '0;
      row_open[1] = '0;
    end
    c = col_pos;
    below = top_row ? rgb_t'('0) : line_below[c];

    src[0] = r;
    src[1] = g;
    src[2] = b;
    for (int ch = 0; ch < 3; ch++) begin
      s = int'(src[ch]) + int'(carry_right[ch]) + int'(below[ch]);
      raised[ch] = (s > 255) ? 8'hFF : 8'(s);
    end

    luma = 64'(raised[0]) * 64'(coef_red_q) + 64'(raised[1]) * 64'(coef_green_q)
         + 64'(raised[2]) * 64'(coef_blue_q);
    white = (luma >= 64'(LUMA_HALF));

    // floored 7/16, 3/16, 5/16, 1/16 shares; white pixels carry no error
    for (int ch = 0; ch < 3; ch++) begin
      e = white ? 0 : int'(raised[ch]);
      share_right[ch] = 8'((e * 7) >> 4);
      share_done[ch]  = 8'(int'(row_open[0][ch]) + ((e * 3) >> 4));
      share_np0[ch]   = 8'(int'(row_open[1][ch]) + ((e * 5) >> 4));
      share_np1[ch]   = 8'(e >> 4);
    end

    if (c > 0) line_below[c-1] = share_done;

    if (c + 1 >= w) begin
      line_below[c] = share_np0;
      carry_right   = '0;
      row_open[0]   = '0;
      row_open[1]   = '0;
      col_pos       = 0;
      top_row       = 1'b0;
    end else begin
      carry_right = share_right;
      row_open[0] = share_np0;
      row_open[1] = share_np1;
      col_pos     = c + 1;
    end
    return white;
  endfunction

  always @(posedge clk) begin : watch
    logic        want;
    logic [31:0] rd_expected;
    reg_idx_t    ridx;

    ridx = reg_idx_t'(paddr[3:2]);
    if (!rst_n) begin
      width_q      = IMG_W_RST;
      coef_red_q   = COEF_R_RST;
      coef_green_q = COEF_G_RST;
      coef_blue_q  = COEF_B_RST;
      col_pos      = 0;
      top_row      = 1'b1;
      carry_right  = '0;
      row_open[0]  = '0;
      row_open[1]  = '0;
      white_expected_q.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (ridx)
            REG_IMAGE_WIDTH: width_q      = pwdata[IMG_W_W-1:0];
            REG_COEF_RED:    coef_red_q   = pwdata[COEF_W-1:0];
            REG_COEF_GREEN:  coef_green_q = pwdata[COEF_W-1:0];
            REG_COEF_BLUE:   coef_blue_q  = pwdata[COEF_W-1:0];
            default: ;
          endcase
        end else begin
          case (ridx)
            REG_IMAGE_WIDTH: rd_expected = 32'(width_q);
            REG_COEF_RED:    rd_expected = 32'(coef_red_q);
            REG_COEF_GREEN:  rd_expected = 32'(coef_green_q);
            default:         rd_expected = 32'(coef_blue_q);
          endcase
          if (prdata !== rd_expected) begin
            $error("%s readback: expected 0x%08h, actual 0x%08h",
                   ridx.name(), rd_expected, prdata);
            mismatches++;
          end
        end
      end

      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (white_expected_q.size() == 0) begin
          $error("is_white: expected no word, actual %0d", out_is_white);
          mismatches++;
        end else begin
          want = white_expected_q.pop_front();
          if (out_is_white !== want) begin
            $error("is_white: expected %0d, actual %0d", want, out_is_white);
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready)
        white_expected_q.push_back(dither_pixel(in_frame_start, in_red_in,
                                                in_green_in, in_blue_in));
    end
    outstanding = white_expected_q.size();
  end

endmodule

`default_nettype wire

### dv/luma_threshold_error_diffusion_core_tb.sv
// ----------------------------------------------------------------------------
// luma_threshold_error_diffusion_core_tb
// Drives pixel words and register writes into the dither core and gives the
// verdict. A directed opening covers black and white extremes, saturation,
// out-of-range widths, frame restarts and a width lowered in mid-row; then
// random frames run under a series of widths and luma weights with random
// idling on both sides and long result back-pressure. Prediction and
// comparison live in the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_threshold_error_diffusion_core_tb import lted_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 16;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_WORDS = 900;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_frame_start = 1'b0;
  logic [PIX_W-1:0]  in_red_in = '0;
  logic [PIX_W-1:0]  in_green_in = '0;
  logic [PIX_W-1:0]  in_blue_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_is_white;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int   fail_count;
  int   words_pending;
  int   cycle_count = 0;
  int   pixels_sent = 0;
  logic calm = 1'b0;  // no random idling on either side while set; the long hold-offs still run

  luma_threshold_error_diffusion_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_frame_start, .in_red_in, .in_green_in, .in_blue_in,
    .out_valid, .out_ready, .out_is_white,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lted_dither_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_frame_start, .in_red_in, .in_green_in, .in_blue_in,
    .out_valid, .out_ready, .out_is_white,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .words_pending
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, plus two long hold-offs to back up the core
  initial begin : result_sink
    int taken;
    int next_hold;
    taken = 0;
    next_hold = 200;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken >= next_hold) begin
        next_hold += 400;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one pixel word and wait for it to be taken
  task automatic send_pixel(input logic fs, input logic [PIX_W-1:0] r, g, b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_frame_start <= fs;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Stop sending and wait for every predicted word to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all four registers, then read them back
  task automatic program_regs(input logic [IMG_W_W-1:0] width,
                              input logic [COEF_W-1:0] cr, cg, cb);
    logic [31:0] vals [4];
    vals[0] = 32'(width);
    vals[1] = 32'(cr);
    vals[2] = 32'(cg);
    vals[3] = 32'(cb);
    for (int i = 0; i < 4; i++) apb_access(1'b1, reg_idx_t'(i), vals[i]);
    for (int i = 0; i < 4; i++) apb_access(1'b0, reg_idx_t'(i), '0);
  endtask

  // Channel level biased toward extremes and mid-gray
  function automatic logic [PIX_W-1:0] pick_level();
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    if (mode < 5) return PIX_W'($urandom_range(160, 96));
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? '1 : '0;
    return COEF_W'($urandom_range(65535));
  endfunction

  initial begin : stimulus
    int                 phase;
    int                 pick;
    int                 n;
    logic [IMG_W_W-1:0] width;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: plain black and white
    send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    drain();

    // width 0 acts as 1: every pixel ends its row; full-scale weights
    program_regs('0, '1, '1, '1);
    send_pixel(1'b1, 8'd128, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd40, 8'd40, 8'd40);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    drain();

    // zero weights: all black, errors pile up and saturate on row two
    program_regs(IMG_W_W'(5), '0, '0, '0);
    for (int k = 0; k < 6; k++) send_pixel(k == 0, 8'd255, 8'd255, 8'd255);
    drain();

    // width lowered under the current column: new row without frame start
    program_regs(IMG_W_W'(1), COEF_R_RST, COEF_G_RST, COEF_B_RST);
    send_pixel(1'b0, 8'd10, 8'd200, 8'd30);
    send_pixel(1'b0, 8'd127, 8'd127, 8'd127);
    send_pixel(1'b0, 8'd128, 8'd128, 8'd128);
    drain();

    // width above the line store acts as its depth; red-only weight
    program_regs('1, '1, '0, '0);
    send_pixel(1'b1, 8'd0, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd127, 8'd0, 8'd0);
    send_pixel(1'b1, 8'd128, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd1, 8'd1, 8'd1);
    drain();

    // random frames, mostly narrow rows so many rows read the line store
    phase = 0;
    n = pixels_sent + RANDOM_WORDS;
    while (pixels_sent < n) begin
      phase++;
      pick = $urandom_range(19);
      if (pick < 14)
        width = IMG_W_W'($urandom_range(12, 1));
      else if (pick < 18)
        width = IMG_W_W'($urandom_range(64, 13));
      else if (pick == 18)
        width = '0;
      else
        width = $urandom_range(1) ? IMG_W_W'(MAX_WIDTH) : '1;
      if ($urandom_range(5) == 0)
        program_regs(width, COEF_R_RST, COEF_G_RST, COEF_B_RST);
      else
        program_regs(width, pick_coef(), pick_coef(), pick_coef());
      calm = (phase == 3);
      pick = $urandom_range(80, 20);
      for (int k = 0; k < pick; k++)
        send_pixel((k == 0) || ($urandom_range(49) == 0),
                   pick_level(), pick_level(), pick_level());
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

### luma_threshold_error_diffusion_core.f
hw/rtl/lted_pkg.sv
hw/rtl/luma_threshold_error_diffusion_core.sv
dv/lted_dither_checker.sv
dv/luma_threshold_error_diffusion_core_tb.sv
